// ----- rtl/dpc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants for the dag path counter
// holds graph sizes, command codes, sequencer states and beat structs
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int unsigned MaxNodes   = 1024;
  localparam int unsigned MaxEdges   = 4096;
  localparam int unsigned NodeW      = $clog2(MaxNodes);
  localparam int unsigned EdgeW      = $clog2(MaxEdges);
  localparam int unsigned LinkW      = $clog2(MaxEdges + 1);
  localparam int unsigned StackDepth = MaxEdges + MaxNodes + 2;
  localparam int unsigned StackW     = $clog2(StackDepth);
  localparam int unsigned PendW      = $clog2(MaxEdges) + 2;
  localparam int unsigned CountW     = 64;

  // list terminator in first_edge / edge_link
  localparam logic [LinkW-1:0] NoEdge = LinkW'(MaxEdges);

  typedef enum logic [1:0] {
    CmdAdd   = 2'd0,
    CmdClear = 2'd1,
    CmdCount = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    StIdle,
    StAddWr,
    StClr,
    StScrClr,
    StSwPop,
    StSwCur,
    StSwChk,
    StSwEdge,
    StSwNb,
    StSwUpd,
    StKInit,
    StKPop,
    StKCur,
    StKLd,
    StKEdge,
    StKNb,
    StKUpd,
    StKFin
  } state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [NodeW-1:0] edge_from;
    logic [NodeW-1:0] edge_to;
    logic [NodeW-1:0] start_node;
    logic [NodeW-1:0] end_node;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] path_count;
    logic              edges_lost;
  } out_t;

endpackage

// ----- rtl/dpc_ram.sv -----
// ----------------------------------------------------------------------------
// dpc_ram: simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dpc_ram #(
  parameter int unsigned DW = 8,
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dag_path_counter_core.sv -----
// ----------------------------------------------------------------------------
// dag_path_counter_core: path counter over a stored directed graph
// edge lists in ram, depth-first reach sweep then kahn propagation
// ----------------------------------------------------------------------------
//  channel | signals                       | beat
//  in      | in_valid_i in_ready_o in_i    | one command (add, clear, count)
//  out     | out_valid_o out_ready_i out_o | one path total, count only
//
//  add edge: accept, then one write state; clear: accept, then a pass over every list head
//  count: scratch clear over every node, then in each of the two passes pop, read and check
//    states per popped node, edge, neighbour and update states per edge, one to close a list
//  reset: a pass over every list head sets each to empty, in_ready_o low
//  the finished total sits in an output register; a new command is taken
//    while it waits, and a later count holds at its end until the slot frees
module dag_path_counter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dpc_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dpc_pkg::out_t out_o
);

  localparam int unsigned NW = dpc_pkg::NodeW;
  localparam int unsigned EW = dpc_pkg::EdgeW;
  localparam int unsigned LW = dpc_pkg::LinkW;
  localparam int unsigned SW = dpc_pkg::StackW;
  localparam int unsigned PW = dpc_pkg::PendW;
  localparam int unsigned CW = dpc_pkg::CountW;

  dpc_pkg::state_e state_q, state_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [LW-1:0]   et_q, et_d;
  logic            drop_q, drop_d;
  logic [SW-1:0]   top_q, top_d;
  logic [NW-1:0]   cur_q, cur_d;
  logic [NW-1:0]   nb_q, nb_d;
  logic [LW-1:0]   k_q, k_d;
  logic [CW-1:0]   cp_q, cp_d;
  dpc_pkg::in_t    req_q, req_d;
  dpc_pkg::out_t   res_q, res_d;
  logic            ov_q, ov_d;

  // ram ports
  logic          fe_we, tg_we, lk_we, pd_we, rc_we, np_we, st_we;
  logic [NW-1:0] fe_wa, fe_ra, pd_wa, pd_ra, rc_wa, rc_ra, np_wa, np_ra;
  logic [EW-1:0] tg_wa, tg_ra;
  logic [SW-1:0] st_wa, st_ra;
  logic [LW-1:0] fe_wd, fe_rd, lk_wd, lk_rd;
  logic [NW-1:0] tg_wd, tg_rd, st_wd, st_rd;
  logic [PW-1:0] pd_wd, pd_rd;
  logic          rc_wd, rc_rd;
  logic [CW-1:0] np_wd, np_rd, sum;
  logic [PW-1:0] pd_dec;
  logic          in_acc;

  dpc_ram #(.DW(LW), .AW(NW)) u_first (
    .clk_i, .we_i(fe_we), .waddr_i(fe_wa), .wdata_i(fe_wd), .raddr_i(fe_ra), .rdata_o(fe_rd));
  dpc_ram #(.DW(NW), .AW(EW)) u_target (
    .clk_i, .we_i(tg_we), .waddr_i(tg_wa), .wdata_i(tg_wd), .raddr_i(tg_ra), .rdata_o(tg_rd));
  dpc_ram #(.DW(LW), .AW(EW)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(tg_wa), .wdata_i(lk_wd), .raddr_i(tg_ra), .rdata_o(lk_rd));
  dpc_ram #(.DW(PW), .AW(NW)) u_pend (
    .clk_i, .we_i(pd_we), .waddr_i(pd_wa), .wdata_i(pd_wd), .raddr_i(pd_ra), .rdata_o(pd_rd));
  dpc_ram #(.DW(1), .AW(NW)) u_reach (
    .clk_i, .we_i(rc_we), .waddr_i(rc_wa), .wdata_i(rc_wd), .raddr_i(rc_ra), .rdata_o(rc_rd));
  dpc_ram #(.DW(CW), .AW(NW)) u_paths (
    .clk_i, .we_i(np_we), .waddr_i(np_wa), .wdata_i(np_wd), .raddr_i(np_ra), .rdata_o(np_rd));
  dpc_ram #(.DW(NW), .AW(SW)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra), .rdata_o(st_rd));

  assign in_ready_o  = (state_q == dpc_pkg::StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_o       = res_q;
  assign sum         = np_rd + cp_q;
  assign pd_dec      = pd_rd - PW'(1);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpc_pkg::StClr;
      cnt_q   <= '0;
      et_q    <= '0;
      drop_q  <= 1'b0;
      top_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      et_q    <= et_d;
      drop_q  <= drop_d;
      top_q   <= top_d;
      ov_q    <= ov_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nb_q  <= nb_d;
    k_q   <= k_d;
    cp_q  <= cp_d;
    req_q <= req_d;
    res_q <= res_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    et_d    = et_q;
    drop_d  = drop_q;
    top_d   = top_q;
    cur_d   = cur_q;
    nb_d    = nb_q;
    k_d     = k_q;
    cp_d    = cp_q;
    req_d   = req_q;
    res_d   = res_q;
    ov_d    = ov_q && !out_ready_i;
    fe_we = 1'b0; fe_wa = '0; fe_wd = '0; fe_ra = '0;
    tg_we = 1'b0; lk_we = 1'b0; tg_wa = '0; tg_wd = '0; lk_wd = '0; tg_ra = '0;
    pd_we = 1'b0; pd_wa = '0; pd_wd = '0; pd_ra = '0;
    rc_we = 1'b0; rc_wa = '0; rc_wd = 1'b0; rc_ra = '0;
    np_we = 1'b0; np_wa = '0; np_wd = '0; np_ra = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;

    case (state_q)
      dpc_pkg::StIdle: begin
        fe_ra = in_i.edge_from;
        if (in_acc) begin
          req_d = in_i;
          cnt_d = '0;
          case (dpc_pkg::cmd_e'(in_i.cmd))
            dpc_pkg::CmdAdd: begin
              if (et_q == LW'(dpc_pkg::MaxEdges)) drop_d = 1'b1;
              else state_d = dpc_pkg::StAddWr;
            end
            dpc_pkg::CmdClear: state_d = dpc_pkg::StClr;
            dpc_pkg::CmdCount: state_d = dpc_pkg::StScrClr;
            default: state_d = dpc_pkg::StIdle;
          endcase
        end
      end
      // link new edge in front of its source list
      dpc_pkg::StAddWr: begin
        tg_we = 1'b1; lk_we = 1'b1;
        tg_wa = et_q[EW-1:0];
        tg_wd = req_q.edge_to;
        lk_wd = fe_rd;
        fe_we = 1'b1;
        fe_wa = req_q.edge_from;
        fe_wd = et_q;
        et_d  = et_q + LW'(1);
        state_d = dpc_pkg::StIdle;
      end
      // empty every list head
      dpc_pkg::StClr: begin
        fe_we = 1'b1; fe_wa = cnt_q; fe_wd = dpc_pkg::NoEdge;
        et_d = '0;
        drop_d = 1'b0;
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NW'(dpc_pkg::MaxNodes - 1)) state_d = dpc_pkg::StIdle;
      end
      // wipe per-count scratch, then seed the sweep stack
      dpc_pkg::StScrClr: begin
        pd_we = 1'b1; pd_wa = cnt_q; pd_wd = '0;
        rc_we = 1'b1; rc_wa = cnt_q; rc_wd = 1'b0;
        np_we = 1'b1; np_wa = cnt_q; np_wd = '0;
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NW'(dpc_pkg::MaxNodes - 1)) begin
          st_we = 1'b1; st_wa = '0; st_wd = req_q.start_node;
          top_d = SW'(1);
          state_d = dpc_pkg::StSwPop;
        end
      end
      // reach sweep
      dpc_pkg::StSwPop: begin
        st_ra = top_q - SW'(1);
        if (top_q == '0) state_d = dpc_pkg::StKInit;
        else begin
          top_d = top_q - SW'(1);
          state_d = dpc_pkg::StSwCur;
        end
      end
      dpc_pkg::StSwCur: begin
        cur_d = st_rd;
        rc_ra = st_rd;
        fe_ra = st_rd;
        state_d = dpc_pkg::StSwChk;
      end
      dpc_pkg::StSwChk: begin
        if (rc_rd) state_d = dpc_pkg::StSwPop;
        else begin
          rc_we = 1'b1; rc_wa = cur_q; rc_wd = 1'b1;
          k_d = fe_rd;
          state_d = dpc_pkg::StSwEdge;
        end
      end
      dpc_pkg::StSwEdge: begin
        tg_ra = k_q[EW-1:0];
        if (k_q == dpc_pkg::NoEdge) state_d = dpc_pkg::StSwPop;
        else state_d = dpc_pkg::StSwNb;
      end
      dpc_pkg::StSwNb: begin
        nb_d = tg_rd;
        k_d = lk_rd;
        pd_ra = tg_rd;
        rc_ra = tg_rd;
        state_d = dpc_pkg::StSwUpd;
      end
      dpc_pkg::StSwUpd: begin
        pd_we = 1'b1; pd_wa = nb_q; pd_wd = pd_rd + PW'(1);
        if (!rc_rd && (top_q < SW'(dpc_pkg::StackDepth))) begin
          st_we = 1'b1; st_wa = top_q; st_wd = nb_q;
          top_d = top_q + SW'(1);
        end
        state_d = dpc_pkg::StSwEdge;
      end
      // kahn propagation
      dpc_pkg::StKInit: begin
        st_we = 1'b1; st_wa = '0; st_wd = req_q.start_node;
        top_d = SW'(1);
        np_we = 1'b1; np_wa = req_q.start_node; np_wd = CW'(1);
        state_d = dpc_pkg::StKPop;
      end
      dpc_pkg::StKPop: begin
        st_ra = top_q - SW'(1);
        np_ra = req_q.end_node;
        if (top_q == '0) state_d = dpc_pkg::StKFin;
        else begin
          top_d = top_q - SW'(1);
          state_d = dpc_pkg::StKCur;
        end
      end
      dpc_pkg::StKCur: begin
        cur_d = st_rd;
        fe_ra = st_rd;
        np_ra = st_rd;
        if (st_rd == req_q.end_node) state_d = dpc_pkg::StKFin;
        else state_d = dpc_pkg::StKLd;
      end
      dpc_pkg::StKLd: begin
        cp_d = np_rd;
        k_d = fe_rd;
        state_d = dpc_pkg::StKEdge;
      end
      dpc_pkg::StKEdge: begin
        tg_ra = k_q[EW-1:0];
        if (k_q == dpc_pkg::NoEdge) state_d = dpc_pkg::StKPop;
        else state_d = dpc_pkg::StKNb;
      end
      dpc_pkg::StKNb: begin
        nb_d = tg_rd;
        k_d = lk_rd;
        np_ra = tg_rd;
        pd_ra = tg_rd;
        state_d = dpc_pkg::StKUpd;
      end
      dpc_pkg::StKUpd: begin
        np_we = 1'b1; np_wa = nb_q; np_wd = sum;
        // self loop feeds back into the running total
        if (nb_q == cur_q) cp_d = sum;
        pd_we = 1'b1; pd_wa = nb_q; pd_wd = pd_dec;
        if ((pd_dec == '0) && (top_q < SW'(dpc_pkg::StackDepth))) begin
          st_we = 1'b1; st_wa = top_q; st_wd = nb_q;
          top_d = top_q + SW'(1);
        end
        state_d = dpc_pkg::StKEdge;
      end
      // hand total to output register once the slot is free
      dpc_pkg::StKFin: begin
        np_ra = req_q.end_node;
        if (!ov_q || out_ready_i) begin
          res_d.path_count = np_rd;
          res_d.edges_lost = drop_q;
          ov_d = 1'b1;
          state_d = dpc_pkg::StIdle;
        end
      end
      default: state_d = dpc_pkg::StIdle;
    endcase
  end

endmodule

// ----- rtl/dpc_checker.sv -----
// ----------------------------------------------------------------------------
// dpc_checker: port-level checks for the dag path counter
// watches handshakes and command-to-result ordering
// ----------------------------------------------------------------------------
module dpc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input dpc_pkg::in_t  in_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input dpc_pkg::out_t out_o
);

  // result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat dropped or changed while stalled");

  // a count keeps the block busy for its scratch clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.cmd == dpc_pkg::CmdCount) |=> !in_ready_o)
    else $error("ready after count beat");

  // add and clear never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.cmd != dpc_pkg::CmdCount) |=> !$rose(out_valid_o))
    else $error("result after non-count beat");

  // a new result only appears while the block is busy finishing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared from idle");

endmodule

bind dag_path_counter_core dpc_checker u_dpc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i, .out_o
);
